FILE: hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the streaming SHA-256 block.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // commands from controller to datapath
    typedef struct packed {
        logic       load_byte;   // write one byte into the block buffer
        logic [1:0] byte_src;    // which byte source feeds the buffer
        logic       start;       // copy hash words into a..h
        logic       round;       // run one compression round
        logic       finish;      // add a..h into the hash words
        logic       count_inc;   // bump the byte count
        logic       clear_msg;   // restore initial hash, clear count and fill
    } sha_cmd_t;

    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    // status from datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] rnd;
    } sha_stat_t;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        case (i)
            3'd0:    init_h = 32'h6a09e667;
            3'd1:    init_h = 32'hbb67ae85;
            3'd2:    init_h = 32'h3c6ef372;
            3'd3:    init_h = 32'ha54ff53a;
            3'd4:    init_h = 32'h510e527f;
            3'd5:    init_h = 32'h9b05688c;
            3'd6:    init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

endpackage

FILE: hw/rtl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, byte count, round registers and hash words.
// ----------------------------------------------------------------------------
module sha_datapath import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    input  logic [7:0]  data_byte,
    input  logic [2:0]  len_sel,      // length byte index, msb first
    input  logic [2:0]  out_sel,
    output sha_stat_t   stat,
    output logic [31:0] hash_word
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [60:0] count_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  rnd_reg;

    logic [63:0] bits;
    logic [7:0]  in_byte;
    logic [3:0]  wi;
    logic [4:0]  sh;
    logic [31:0] w2, w15, w7, w16, wnew, wr;
    logic [31:0] s0, s1, t1, t2, e, a;

    assign bits = {count_reg, 3'b000};
    assign stat.fill = fill_reg;
    assign stat.rnd  = rnd_reg;
    assign hash_word = h_reg[out_sel];

    // byte source selection
    always_comb begin
        case (cmd.byte_src)
            SRC_DATA: in_byte = data_byte;
            SRC_PAD:  in_byte = PAD_BYTE;
            SRC_ZERO: in_byte = 8'd0;
            default:  in_byte = bits[{~len_sel, 3'b000} +: 8];
        endcase
    end

    assign wi = fill_reg[5:2];
    assign sh = {2'd3 - fill_reg[1:0], 3'b000};

    // schedule word for this round
    assign w2   = w_reg[4'(rnd_reg[3:0] - 4'd2)];
    assign w15  = w_reg[4'(rnd_reg[3:0] - 4'd15)];
    assign w7   = w_reg[4'(rnd_reg[3:0] - 4'd7)];
    assign w16  = w_reg[rnd_reg[3:0]];
    assign s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    assign s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    assign wnew = s1 + w7 + s0 + w16;
    assign wr   = (rnd_reg >= 6'd16) ? wnew : w16;

    // round function
    assign a  = v_reg[0];
    assign e  = v_reg[4];
    assign t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[rnd_reg] + wr;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // block buffer and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            if (fill_reg[1:0] == 2'd0) begin
                w_reg[wi] <= {in_byte, 24'd0};
            end else begin
                w_reg[wi] <= w_reg[wi] | ({24'd0, in_byte} << sh);
            end
        end else if (cmd.round) begin
            w_reg[rnd_reg[3:0]] <= wr;
        end
        if (cmd.start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (cmd.round) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // hash words, counters
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_msg) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= init_h(3'(i));
            count_reg <= '0;
            fill_reg  <= '0;
        end else begin
            if (cmd.finish) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.count_inc) count_reg <= count_reg + 61'd1;
            if (cmd.load_byte) fill_reg <= fill_reg + 6'd1;
        end
        if (!aresetn || cmd.start) begin
            rnd_reg <= '0;
        end else if (cmd.round) begin
            rnd_reg <= rnd_reg + 6'd1;
        end
    end

endmodule

FILE: hw/rtl/sha_control.sv
// ----------------------------------------------------------------------------
// sha_control
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha_control import sha_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      has_byte,
    input  logic      last_byte,
    input  sha_stat_t stat,
    output sha_cmd_t  cmd,
    output logic [2:0] len_sel,
    output logic [2:0] out_sel,
    output logic      m_tvalid,
    input  logic      m_tready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;     // where to resume after a block
    logic       fin_reg, fin_next;     // padding in progress
    logic [2:0] cnt_reg, cnt_next;
    logic       full;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign len_sel  = cnt_reg;
    assign out_sel  = cnt_reg;
    // a byte written at fill 63 completes the block
    assign full     = (stat.fill == 6'd63);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fin_next   = fin_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_byte = has_byte;
                    cmd.count_inc = has_byte;
                    fin_next = last_byte;
                    if (has_byte && full) begin
                        cmd.start  = 1'b1;
                        ret_next   = last_byte ? ST_PAD : ST_IDLE;
                        state_next = ST_ROUND;
                    end else if (last_byte) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.load_byte = 1'b1;
                cmd.byte_src  = SRC_PAD;
                state_next    = ST_ZERO;
                if (full) begin
                    cmd.start  = 1'b1;
                    ret_next   = ST_ZERO;
                    state_next = ST_ROUND;
                end
            end
            ST_ZERO: begin
                if (stat.fill == LEN_POS) begin
                    cnt_next   = '0;
                    state_next = ST_LEN;
                end else begin
                    cmd.load_byte = 1'b1;
                    cmd.byte_src  = SRC_ZERO;
                    if (full) begin
                        cmd.start  = 1'b1;
                        ret_next   = ST_ZERO;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_LEN: begin
                cmd.load_byte = 1'b1;
                cmd.byte_src  = SRC_LEN;
                cnt_next      = cnt_reg + 3'd1;
                if (full) begin
                    cmd.start  = 1'b1;
                    ret_next   = ST_OUT;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (stat.rnd == 6'd63) state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.finish = 1'b1;
                cnt_next   = '0;
                state_next = ret_reg;
            end
            ST_OUT: begin
                if (m_tready) begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        cmd.clear_msg = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fin_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fin_reg   <= fin_next;
            cnt_reg   <= cnt_next;
        end
    end

    // digest words go out only while a message is being closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> fin_reg)
        else $error("digest output outside a closing message");
    // rounds never start from the output phase or while rounds are running
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (state_reg != ST_OUT && state_reg != ST_ROUND))
        else $error("compression started from a wrong state");
    // after the last digest word the block is ready again
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && cnt_reg == 3'd7) |=> s_tready)
        else $error("not ready after digest");

endmodule

FILE: hw/rtl/sha256_stream_hash.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash
// Streaming SHA-256, one message byte per input item, eight digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side takes one byte per item: s_tdata is the byte, s_tuser says it is
//   valid (has_byte) and s_tlast ends the message. An item with s_tuser low
//   and s_tlast high ends the message with the bytes already taken.
//   m_ side gives eight items after each message: a digest word H0..H7 in
//   m_tdata, its index in m_tuser, m_tlast on H7.
// Intake: s_tready is high only while idle, so no byte is taken during
//   padding, compression or digest output. Every 64th byte starts 64
//   rounds and one add step, one round per cycle in the shared round unit.
// Closing: after the last item, padding writes the 0x80 byte, zeros up to
//   the length field and the eight length bytes, msb first, one byte per
//   cycle apart from the switch to the length and the compression of each
//   full block; digest words follow, one per cycle while m_tready is high.
// While digest words are shown, s_tready is low; a stalled receiver holds
//   the current word stable. Reset restores the initial hash values and
//   clears the byte count; no item is in flight after reset.
// ----------------------------------------------------------------------------
module sha256_stream_hash import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tuser,    // has_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // digest_word
    output logic [2:0]  m_tuser,    // word_index
    output logic        m_tlast     // last_word
);

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] len_sel;
    logic [2:0] out_sel;

    sha_control u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .has_byte  (s_tuser),
        .last_byte (s_tlast),
        .stat      (stat),
        .cmd       (cmd),
        .len_sel   (len_sel),
        .out_sel   (out_sel),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

    sha_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .len_sel   (len_sel),
        .out_sel   (out_sel),
        .stat      (stat),
        .hash_word (m_tdata)
    );

    assign m_tuser = out_sel;
    assign m_tlast = (out_sel == 3'd7);

endmodule
